// ===== src/xorshift128plus_generator_macros.svh =====
// Assertion helpers shared by the generator RTL.
// Each clocks on clk and is off while rst_n is low.
`ifndef XORSHIFT128PLUS_GENERATOR_MACROS_SVH
`define XORSHIFT128PLUS_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define XR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define XR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/xr128p_pkg.sv =====
`default_nettype none
package xr128p_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned INT_W    = 31;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned SHIFT_A  = 23;
  localparam int unsigned SHIFT_B  = 17;
  localparam int unsigned SHIFT_C  = 26;
  localparam int unsigned COIN_BIT = 20;

  localparam logic [WORD_W-1:0] SEED_LOW_RESET  = 64'd1;
  localparam logic [WORD_W-1:0] SEED_HIGH_RESET = 64'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== src/xorshift128plus_generator.sv =====
`default_nettype none
`include "xorshift128plus_generator_macros.svh"
// Per beat: the state words advance on the accepted beat, the divider is
//   launched, runs 31 remainder steps and pulses done, then the output register loads once free.
// A new beat is taken only in idle, after the last one is loaded; the 31-step
//   restoring remainder unit sets the pace. A finished beat waits in the output
//   register while the next one runs. Reset: state words load seeds 1 and 2.
module xorshift128plus_generator (
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [30:0] in_range_limit,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] out_raw_value,
  output logic        out_coin,
  output logic [30:0] out_nonneg_int,
  output logic [30:0] out_bounded_int,
  output logic        out_limit_error,
  // seed register writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [63:0] cfg_data
);
  import xr128p_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [INT_W-1:0]  limit_r, limit_nxt;
  logic              in_take;
  logic              advance;
  logic              div_start;
  logic              out_load;
  logic [WORD_W-1:0] raw_value;
  logic [INT_W-1:0]  remainder;
  cfg_wr_t           cfg_wr;
  div_stat_t         dstat;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_raw_r;
  logic              out_coin_r;
  logic [INT_W-1:0]  out_nonneg_r;
  logic [INT_W-1:0]  out_bounded_r;
  logic              out_err_r;

  // Seed writes are always taken; the user must let them arrive only while the block is idle (not enforced here).
  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Sequencer: advance the state on the accepted beat, launch the remainder
  // unit on the fresh draw, wait it out, then park the result in the output
  // register as soon as that register is free.
  always_comb begin
    state_nxt = state_r;
    limit_nxt = limit_r;
    advance   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          advance   = 1'b1;
          limit_nxt = in_range_limit;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (dstat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    if (out_load) begin
      out_raw_r     <= raw_value;
      out_coin_r    <= raw_value[COIN_BIT];
      out_nonneg_r  <= raw_value[INT_W-1:0];
      // zero limit: remainder forced to 0 and flagged
      out_bounded_r <= (limit_r == '0) ? '0 : remainder;
      out_err_r     <= (limit_r == '0);
    end
  end

  xr128p_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .advance   (advance),
    .raw_value (raw_value)
  );

  xr128p_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (raw_value[INT_W-1:0]),
    .divisor   (limit_r),
    .stat      (dstat),
    .remainder (remainder)
  );

  assign out_valid       = out_valid_r;
  assign out_raw_value   = out_raw_r;
  assign out_coin        = out_coin_r;
  assign out_nonneg_int  = out_nonneg_r;
  assign out_bounded_int = out_bounded_r;
  assign out_limit_error = out_err_r;

  `XR_ASSERT_NEXT(a_take_launch, in_take, state_r == ST_START && !dstat.busy,
    "accepted beat did not reach divider launch")
  `XR_ASSERT_NOW(a_done_in_run, dstat.done, state_r == ST_RUN,
    "remainder finished outside the run state")
  `XR_ASSERT_NOW(a_err_zero, out_valid_r && out_err_r, out_bounded_r == '0,
    "flagged beat carries a nonzero remainder")

endmodule
`default_nettype wire

// ===== src/xr128p_core.sv =====
`default_nettype none
module xr128p_core (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire xr128p_pkg::cfg_wr_t      cfg_wr,
  input  wire                           advance,
  output logic [xr128p_pkg::WORD_W-1:0] raw_value
);
  import xr128p_pkg::*;

  logic [WORD_W-1:0] word_first_r, word_first_nxt;
  logic [WORD_W-1:0] word_second_r, word_second_nxt;
  logic [WORD_W-1:0] raw_r, raw_nxt;
  logic [WORD_W-1:0] t1, t2, t3;

  // one xorshift128+ step
  always_comb begin
    t1 = word_first_r ^ (word_first_r << SHIFT_A);
    t2 = t1 ^ (t1 >> SHIFT_B);
    t3 = t2 ^ word_second_r ^ (word_second_r >> SHIFT_C);
  end

  always_comb begin
    word_first_nxt  = word_first_r;
    word_second_nxt = word_second_r;
    raw_nxt         = raw_r;
    if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        REG_SEED_LOW:  word_first_nxt  = cfg_wr.data;
        REG_SEED_HIGH: word_second_nxt = cfg_wr.data;
        default: ;
      endcase
    end else if (advance) begin
      word_first_nxt  = word_second_r;
      word_second_nxt = t3;
      raw_nxt         = t3 + word_second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_first_r  <= SEED_LOW_RESET;
      word_second_r <= SEED_HIGH_RESET;
    end else begin
      word_first_r  <= word_first_nxt;
      word_second_r <= word_second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
  end

  assign raw_value = raw_r;

endmodule
`default_nettype wire

// ===== src/xr128p_divider.sv =====
`default_nettype none
`include "xorshift128plus_generator_macros.svh"
module xr128p_divider (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [xr128p_pkg::INT_W-1:0]  dividend,
  input  wire [xr128p_pkg::INT_W-1:0]  divisor,
  output xr128p_pkg::div_stat_t        stat,
  output logic [xr128p_pkg::INT_W-1:0] remainder
);
  import xr128p_pkg::*;

  localparam int unsigned CNT_W = $clog2(INT_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(INT_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [INT_W-1:0] dvd_r, dvd_nxt;
  logic [INT_W-1:0] dsr_r, dsr_nxt;
  logic [INT_W:0]   rem_r, rem_nxt;
  logic [INT_W:0]   rem_sh;
  logic [INT_W+1:0] diff;

  // restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_r[INT_W-1:0], dvd_r[INT_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEPS;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[INT_W-2:0], 1'b0};
      rem_nxt = diff[INT_W+1] ? rem_sh : diff[INT_W:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r[INT_W-1:0];

  `XR_ASSERT_NOW(a_no_restart, start, !busy_r, "divider restarted while busy")
  `XR_ASSERT_NEXT(a_last_step, busy_r && !start && cnt_r == CNT_W'(1), done_r && !busy_r,
    "divider missed its last step")
  `XR_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "divider done held longer than a cycle")

endmodule
`default_nettype wire
